/* src/uer_pkg.sv */
package uer_pkg;

  localparam int ENTRY_W = 16;
  localparam int SCALE_W = 16;
  localparam int FRAC_W  = 16;

  localparam logic [1:0] CFG_TRIGGER_TICKS   = 2'd0;
  localparam logic [1:0] CFG_REARM_GAP_TICKS = 2'd1;
  localparam logic [1:0] CFG_ECHO_WAIT_LIMIT = 2'd2;
  localparam logic [1:0] CFG_DISTANCE_SCALE  = 2'd3;

  typedef struct packed {
    logic               trig;
    logic               rec;
    logic [ENTRY_W-1:0] width;
  } step_t;

endpackage

/* src/uer_ctrl.sv */
module uer_ctrl #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          echo,
  input  logic [7:0]    trigger_ticks,
  input  logic [15:0]   rearm_gap_ticks,
  input  logic [15:0]   echo_wait_limit,
  output uer_pkg::step_t step
);

  localparam logic [1:0] PH_REARM   = 2'd0;
  localparam logic [1:0] PH_TRIGGER = 2'd1;
  localparam logic [1:0] PH_WAIT    = 2'd2;
  localparam logic [1:0] PH_MEASURE = 2'd3;

  localparam int CMP_W = (COUNT_WIDTH > uer_pkg::ENTRY_W) ? COUNT_WIDTH : uer_pkg::ENTRY_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [CMP_W-1:0] CNT_MAX_EXT = CMP_W'(CNT_MAX);
  localparam logic [CMP_W-1:0] ENTRY_MAX_EXT = CMP_W'({uer_pkg::ENTRY_W{1'b1}});

  logic [1:0]             phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic [COUNT_WIDTH-1:0] tick_inc;
  logic [CMP_W-1:0]       cnt_ext, inc_ext;
  logic [CMP_W-1:0]       gap_lim, trig_lim, wait_lim;
  logic [7:0]             trig_eff;
  logic [15:0]            wait_eff;
  logic                   rec;

  function automatic logic [CMP_W-1:0] clip_lim(input logic [15:0] v);
    logic [CMP_W-1:0] ext;
    begin
      ext = CMP_W'(v);
      clip_lim = (ext > CNT_MAX_EXT) ? CNT_MAX_EXT : ext;
    end
  endfunction

  assign tick_inc = (tick_r == CNT_MAX) ? tick_r : tick_r + COUNT_WIDTH'(1);
  assign cnt_ext  = CMP_W'(tick_r);
  assign inc_ext  = CMP_W'(tick_inc);
  assign trig_eff = (trigger_ticks == 8'd0) ? 8'd1 : trigger_ticks;
  assign wait_eff = (echo_wait_limit == 16'd0) ? 16'd1 : echo_wait_limit;
  assign gap_lim  = clip_lim(rearm_gap_ticks);
  assign trig_lim = clip_lim({8'd0, trig_eff});
  assign wait_lim = clip_lim(wait_eff);

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    rec       = 1'b0;
    unique case (phase_r)
      PH_REARM: begin
        if (cnt_ext >= gap_lim) begin
          phase_nxt = PH_TRIGGER;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      PH_TRIGGER: begin
        tick_nxt = tick_inc;
        if (inc_ext >= trig_lim) begin
          phase_nxt = PH_WAIT;
          tick_nxt  = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          phase_nxt = PH_MEASURE;
          tick_nxt  = '0;
        end else if (inc_ext >= wait_lim) begin
          phase_nxt = PH_REARM;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_inc;
        end
      end
      PH_MEASURE: begin
        tick_nxt = tick_inc;
        if (!echo) begin
          rec       = 1'b1;
          phase_nxt = PH_REARM;
          tick_nxt  = '0;
        end
      end
    endcase
  end

  assign step.trig  = (phase_nxt == PH_TRIGGER);
  assign step.rec   = rec;
  assign step.width = (inc_ext > ENTRY_MAX_EXT) ? {uer_pkg::ENTRY_W{1'b1}}
                                                : inc_ext[uer_pkg::ENTRY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_REARM;
      tick_r  <= '0;
    end else if (en) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
    end
  end

  a_rec_from_measure: assert property (@(posedge clk) disable iff (!rst_n)
    step.rec |-> (phase_r == PH_MEASURE) && (step.width != '0))
    else $error("echo width recorded outside the measure phase or as zero");

endmodule

/* src/uer_hist.sv */
module uer_hist #(
  parameter int HISTORY_DEPTH = 3,
  parameter int SUM_W         = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  uer_pkg::step_t   step,
  output logic [SUM_W-1:0] sum_nxt
);

  logic [uer_pkg::ENTRY_W-1:0] hist_r   [HISTORY_DEPTH];
  logic [uer_pkg::ENTRY_W-1:0] hist_nxt [HISTORY_DEPTH];
  logic [SUM_W-1:0]            sum_r;
  logic                        older_zero;

  always_comb begin
    older_zero = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
      if (hist_r[i] != '0) begin
        older_zero = 1'b0;
      end
    end
  end

  always_comb begin
    hist_nxt[0] = step.width;
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      hist_nxt[i] = older_zero ? step.width : hist_r[i-1];
    end
  end

  always_comb begin
    if (!step.rec) begin
      sum_nxt = sum_r;
    end else if (older_zero) begin
      sum_nxt = SUM_W'(SUM_W'(step.width) * SUM_W'(HISTORY_DEPTH));
    end else begin
      sum_nxt = sum_r - SUM_W'(hist_r[HISTORY_DEPTH-1]) + SUM_W'(step.width);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else if (en && step.rec) begin
      sum_r <= sum_nxt;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= hist_nxt[i];
      end
    end
  end

endmodule

/* src/uer_dist.sv */
module uer_dist #(
  parameter int SUM_W = 18
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic                         unload,
  input  logic                         trig,
  input  logic                         fresh,
  input  logic [SUM_W-1:0]             sum,
  input  logic [uer_pkg::SCALE_W-1:0]  scale,
  output logic                         out_valid,
  output logic                         out_trigger_level,
  output logic                         out_pin_is_output,
  output logic [uer_pkg::ENTRY_W-1:0]  out_distance_mm,
  output logic                         out_new_reading
);

  localparam int PROD_W = SUM_W + uer_pkg::SCALE_W;
  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (uer_pkg::FRAC_W - 1);

  logic [PROD_W-1:0]                 prod;
  logic [PROD_W:0]                   rnd;
  logic [PROD_W-uer_pkg::FRAC_W:0]   quot;
  logic [uer_pkg::ENTRY_W-1:0]       dist_nxt;
  logic                              valid_r;
  logic                              trig_r;
  logic                              fresh_r;
  logic [uer_pkg::ENTRY_W-1:0]       dist_r;

  assign prod = PROD_W'(sum) * PROD_W'(scale);
  assign rnd  = {1'b0, prod} + ROUND_HALF;
  assign quot = rnd[PROD_W:uer_pkg::FRAC_W];
  assign dist_nxt = (|quot[PROD_W-uer_pkg::FRAC_W:uer_pkg::ENTRY_W])
                  ? {uer_pkg::ENTRY_W{1'b1}} : quot[uer_pkg::ENTRY_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (unload) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      trig_r  <= trig;
      fresh_r <= fresh;
      dist_r  <= dist_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_trigger_level = trig_r;
  assign out_pin_is_output = trig_r;
  assign out_distance_mm   = dist_r;
  assign out_new_reading   = fresh_r;

endmodule

/* src/ultrasonic_echo_ranger_top.sv */
// Ultrasonic echo ranger: each input request is one sampled tick of the sensor pin, and each
// one yields exactly one result that carries the pin drive for that tick, the averaged distance
// in millimetres and a flag on the tick an echo measurement completes. The block accepts one
// request per clock cycle while in_ready is high; a result is presented at the output once
// it has passed the state update stage and the scale multiplier stage. in_ready falls only while
// both the middle stage and the output register hold results that the consumer has not taken.
// Configuration writes are always accepted and should be made only while no request is in flight.
module ultrasonic_echo_ranger_top #(
  parameter int COUNT_WIDTH   = 16,
  parameter int HISTORY_DEPTH = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_echo_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_trigger_level,
  output logic        out_pin_is_output,
  output logic [15:0] out_distance_mm,
  output logic        out_new_reading,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SUM_W = uer_pkg::ENTRY_W + $clog2(HISTORY_DEPTH);

  logic [7:0]       trigger_ticks_r;
  logic [15:0]      rearm_gap_ticks_r;
  logic [15:0]      echo_wait_limit_r;
  logic [15:0]      distance_scale_r;

  uer_pkg::step_t   step;
  logic [SUM_W-1:0] sum_nxt;
  logic             accept;
  logic             out_free;
  logic             s1_move;
  logic             s1_valid_r;
  logic             s1_trig_r;
  logic             s1_fresh_r;
  logic [SUM_W-1:0] s1_sum_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_ticks_r   <= 8'd15;
      rearm_gap_ticks_r <= 16'd200;
      echo_wait_limit_r <= 16'd1;
      distance_scale_r  <= 16'd3779;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        uer_pkg::CFG_TRIGGER_TICKS:   trigger_ticks_r   <= cfg_data[7:0];
        uer_pkg::CFG_REARM_GAP_TICKS: rearm_gap_ticks_r <= cfg_data;
        uer_pkg::CFG_ECHO_WAIT_LIMIT: echo_wait_limit_r <= cfg_data;
        uer_pkg::CFG_DISTANCE_SCALE:  distance_scale_r  <= cfg_data;
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;
  assign s1_move  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign accept   = in_valid && in_ready;

  uer_ctrl #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (accept),
    .echo            (in_echo_level),
    .trigger_ticks   (trigger_ticks_r),
    .rearm_gap_ticks (rearm_gap_ticks_r),
    .echo_wait_limit (echo_wait_limit_r),
    .step            (step)
  );

  uer_hist #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .SUM_W        (SUM_W)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (accept),
    .step    (step),
    .sum_nxt (sum_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_trig_r  <= step.trig;
      s1_fresh_r <= step.rec;
      s1_sum_r   <= sum_nxt;
    end
  end

  uer_dist #(
    .SUM_W(SUM_W)
  ) u_dist (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (s1_move),
    .unload            (out_ready),
    .trig              (s1_trig_r),
    .fresh             (s1_fresh_r),
    .sum               (s1_sum_r),
    .scale             (distance_scale_r),
    .out_valid         (out_valid),
    .out_trigger_level (out_trigger_level),
    .out_pin_is_output (out_pin_is_output),
    .out_distance_mm   (out_distance_mm),
    .out_new_reading   (out_new_reading)
  );

  a_stage_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid)
    else $error("middle stage advanced but no result reached the output register");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted request did not reach the middle stage");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the output register is empty");

endmodule

/* dv/tb_ultrasonic_echo_ranger_top.sv */
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_top;

  localparam int HIST_DEPTH     = 3;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_ECHO      = 120;

  typedef enum logic [1:0] {
    RNG_REARM,
    RNG_TRIGGER,
    RNG_LISTEN,
    RNG_TIMING
  } range_phase_e;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic        trig;
    logic        drive;
    logic [15:0] dist_mm;
    logic        fresh;
  } ranging_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_echo_level = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_trigger_level;
  logic        out_pin_is_output;
  logic [15:0] out_distance_mm;
  logic        out_new_reading;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  logic [7:0]  cfg_trigger = 8'd15;
  logic [15:0] cfg_gap = 16'd200;
  logic [15:0] cfg_listen = 16'd1;
  logic [15:0] cfg_scale = 16'd3779;

  range_phase_e                rng_phase = RNG_REARM;
  logic [15:0]                 rng_count = 16'd0;
  logic [uer_pkg::ENTRY_W-1:0] echo_hist [HIST_DEPTH] = '{default: '0};

  logic     pending_echo[$];
  ranging_t expected_ranging[$];
  int       items_queued = 0;
  int       results_seen = 0;
  int       fails = 0;
  int       quiet_cycles = 0;
  int       hold_left = 0;
  logic     hold_done = 1'b0;
  logic     want_hold = 1'b0;

  idle_mode_e idle_mode = IDLE_NONE;

  ultrasonic_echo_ranger_top #(
    .COUNT_WIDTH  (16),
    .HISTORY_DEPTH(HIST_DEPTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_echo_level    (in_echo_level),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_trigger_level(out_trigger_level),
    .out_pin_is_output(out_pin_is_output),
    .out_distance_mm  (out_distance_mm),
    .out_new_reading  (out_new_reading),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] bump(input logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

  function automatic ranging_t advance_ranger(input logic echo);
    ranging_t    r;
    logic [15:0] lim;
    logic [17:0] sum;
    logic [35:0] prod;
    logic        seed;
    r = '0;
    case (rng_phase)
      RNG_REARM: begin
        if (rng_count >= cfg_gap) begin
          rng_phase = RNG_TRIGGER;
          rng_count = '0;
        end else begin
          rng_count = bump(rng_count);
        end
      end
      RNG_TRIGGER: begin
        rng_count = bump(rng_count);
        lim = (cfg_trigger == 8'd0) ? 16'd1 : {8'd0, cfg_trigger};
        if (rng_count >= lim) begin
          rng_phase = RNG_LISTEN;
          rng_count = '0;
        end
      end
      RNG_LISTEN: begin
        if (echo) begin
          rng_phase = RNG_TIMING;
          rng_count = '0;
        end else begin
          rng_count = bump(rng_count);
          lim = (cfg_listen == 16'd0) ? 16'd1 : cfg_listen;
          if (rng_count >= lim) begin
            rng_phase = RNG_REARM;
            rng_count = '0;
          end
        end
      end
      default: begin
        rng_count = bump(rng_count);
        if (!echo) begin
          for (int i = HIST_DEPTH - 1; i > 0; i--) echo_hist[i] = echo_hist[i-1];
          echo_hist[0] = rng_count;
          seed = 1'b1;
          for (int i = 1; i < HIST_DEPTH; i++) if (echo_hist[i] != '0) seed = 1'b0;
          if (seed) for (int i = 1; i < HIST_DEPTH; i++) echo_hist[i] = rng_count;
          r.fresh = 1'b1;
          rng_phase = RNG_REARM;
          rng_count = '0;
        end
      end
    endcase
    sum = '0;
    for (int i = 0; i < HIST_DEPTH; i++) sum = sum + echo_hist[i];
    prod = (sum * cfg_scale + 36'd32768) >> uer_pkg::FRAC_W;
    r.dist_mm = (prod > 36'hFFFF) ? 16'hFFFF : prod[15:0];
    r.trig = (rng_phase == RNG_TRIGGER);
    r.drive = (rng_phase == RNG_TRIGGER);
    return r;
  endfunction

  function automatic logic sender_rests();
    return (idle_mode == IDLE_SENDER && $urandom_range(99) < 87) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 13);
  endfunction

  function automatic logic receiver_stalls();
    return (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 87) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 13);
  endfunction

  task automatic check_field(input string name, input int unsigned want, got);
    if (want != got) begin
      fails++;
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_ranging.push_back(advance_ranger(in_echo_level));
      end
      if (!in_valid || in_ready) begin
        if (pending_echo.size() != 0 && !sender_rests()) begin
          in_valid <= 1'b1;
          in_echo_level <= pending_echo.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    ranging_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_ranging.size() == 0) begin
          fails++;
          $error("result with no request pending");
        end else begin
          want = expected_ranging.pop_front();
          check_field("trigger_level", 32'(want.trig), 32'(out_trigger_level));
          check_field("pin_is_output", 32'(want.drive), 32'(out_pin_is_output));
          check_field("distance_mm", 32'(want.dist_mm), 32'(out_distance_mm));
          check_field("new_reading", 32'(want.fresh), 32'(out_new_reading));
        end
      end
      if (want_hold && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !receiver_stalls();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL ultrasonic_echo_ranger_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_echo(input logic level);
    pending_echo.push_back(level);
    items_queued++;
  endtask

  task automatic queue_bits(input string bits);
    for (int i = 0; i < bits.len(); i++) push_echo(bits[i] == "1");
  endtask

  // Mostly a low stretch then an echo pulse, with some random noise mixed in.
  task automatic queue_echoes(input int n, input int low_max);
    int stop;
    stop = items_queued + n;
    while (items_queued < stop) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 8)) push_echo(1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(0, low_max)) push_echo(1'b0);
        repeat ($urandom_range(1, 12)) push_echo(1'b1);
      end
    end
  endtask

  task automatic settle();
    while (results_seen < items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      uer_pkg::CFG_TRIGGER_TICKS:   cfg_trigger = val[7:0];
      uer_pkg::CFG_REARM_GAP_TICKS: cfg_gap = val;
      uer_pkg::CFG_ECHO_WAIT_LIMIT: cfg_listen = val;
      uer_pkg::CFG_DISTANCE_SCALE:  cfg_scale = val;
      default: ;
    endcase
  endtask

  task automatic program_ranger(input logic [15:0] trig, gap, listen, scale,
                                input idle_mode_e mode);
    settle();
    cfg_valid <= 1'b1;
    write_reg(uer_pkg::CFG_TRIGGER_TICKS, trig);
    write_reg(uer_pkg::CFG_REARM_GAP_TICKS, gap);
    write_reg(uer_pkg::CFG_ECHO_WAIT_LIMIT, listen);
    write_reg(uer_pkg::CFG_DISTANCE_SCALE, scale);
    cfg_valid <= 1'b0;
    idle_mode <= mode;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Echo activity during the re-arm wait is ignored.
    queue_bits("10101");
    // A zero trigger width and a zero wait limit both act as one tick.
    program_ranger(16'hFF00, 16'd0, 16'd0, 16'hFFFF, IDLE_NONE);
    // The first width seeds the whole history, then a timeout, then widths 2 and 3.
    queue_bits("0010");
    queue_bits("000");
    queue_bits("00110");
    queue_bits("001110");

    program_ranger(16'd3, 16'd2, 16'd20, 16'd3779, IDLE_NONE);
    want_hold <= 1'b1;
    queue_echoes(100, 30);

    program_ranger(16'd1, 16'd0, 16'd1, 16'hFFFF, IDLE_SENDER);
    queue_echoes(120, 4);

    program_ranger(16'h00FF, 16'd0, 16'hFFFF, 16'd0, IDLE_RECEIVER);
    queue_echoes(150, 300);

    program_ranger(16'd8, 16'hFFFF, 16'd10, 16'd12345, IDLE_BOTH);
    queue_echoes(40, 10);

    program_ranger(16'd2, 16'd1, 16'd6, 16'($urandom_range(16'hFFFF)), IDLE_BOTH);
    queue_echoes(100, 12);

    // A long pulse at full scale gives a large width and distance.
    program_ranger(16'd1, 16'd0, 16'hFFFF, 16'hFFFF, IDLE_NONE);
    queue_bits("000");
    repeat (LONG_ECHO) push_echo(1'b1);
    push_echo(1'b0);
    queue_echoes(20, 4);

    settle();
    repeat (8) @(posedge clk);
    if (expected_ranging.size() != 0) begin
      fails++;
      $error("%0d results never arrived", expected_ranging.size());
    end
    if (fails == 0) begin
      $display("PASS ultrasonic_echo_ranger_top");
    end else begin
      $display("FAIL ultrasonic_echo_ranger_top");
    end
    $finish;
  end

endmodule
